// File: hdl/cbrms_pkg.sv
// ----------------------------------------------------------------------------
// cbrms_pkg
// Shared types and constants of the calibrated block RMS meter.
// ----------------------------------------------------------------------------
package cbrms_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd2;

  localparam logic signed [23:0] GAIN_RESET = 24'sd28422;
  localparam logic signed [23:0] OFFSET_RESET = -24'sd911;
  localparam logic [15:0] BLOCK_LENGTH_RESET = 16'd500;

  localparam logic signed [42:0] CUR_MAX = 43'sd8388607;
  localparam logic signed [42:0] CUR_MIN = -43'sd8388608;

  localparam logic [5:0] DIV_LAST_STEP = 6'd63;
  localparam logic [5:0] SQRT_LAST_STEP = 6'd31;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [16:0] divisor;
  } root_req_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic [31:0] root;
  } root_rsp_t;

endpackage

// File: hdl/cbrms_root_unit.sv
// ----------------------------------------------------------------------------
// cbrms_root_unit
// Square root of a quotient: restoring divide, one bit per cycle, then a
// digit-by-digit square root, two radicand bits per cycle, on one subtractor.
// ----------------------------------------------------------------------------
module cbrms_root_unit
  import cbrms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  root_req_t req,
  output root_rsp_t rsp
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_DIV  = 4'b0010,
    U_SQRT = 4'b0100,
    U_DONE = 4'b1000
  } ustate_t;

  ustate_t     state;
  logic [5:0]  step;
  logic [63:0] work;
  logic [33:0] rem;
  logic [31:0] root;
  logic [16:0] divisor;

  logic [17:0] div_a;
  logic [33:0] op_a;
  logic [33:0] op_b;
  logic [34:0] diff;
  logic        ge;

  assign div_a = {rem[16:0], work[63]};

  always_comb begin
    if (state == U_SQRT) begin
      op_a = {rem[31:0], work[63:62]};
      op_b = {root, 2'b01};
    end else begin
      op_a = {16'd0, div_a};
      op_b = {17'd0, divisor};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge = ~diff[34];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      step <= '0;
    end else begin
      unique case (state)
        U_IDLE: begin
          if (req.start) begin
            state <= U_DIV;
            step <= '0;
          end
        end
        U_DIV: begin
          step <= step + 6'd1;
          if (step == DIV_LAST_STEP) begin
            state <= U_SQRT;
            step <= '0;
          end
        end
        U_SQRT: begin
          step <= step + 6'd1;
          if (step == SQRT_LAST_STEP) begin
            state <= U_DONE;
          end
        end
        U_DONE: state <= U_IDLE;
        default: state <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: begin
        if (req.start) begin
          work <= req.dividend;
          divisor <= req.divisor;
          rem <= '0;
          root <= '0;
        end
      end
      U_DIV: begin
        work <= {work[62:0], ge};
        rem <= ge ? diff[33:0] : op_a;
        if (step == DIV_LAST_STEP) begin
          rem <= '0;
        end
      end
      U_SQRT: begin
        work <= {work[61:0], 2'b00};
        rem <= ge ? diff[33:0] : op_a;
        root <= {root[30:0], ge};
      end
      default: begin
        work <= work;
      end
    endcase
  end

  assign rsp.idle = (state == U_IDLE);
  assign rsp.done = (state == U_DONE);
  assign rsp.root = root;

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == U_IDLE)
    else $error("root unit started while busy");

  a_sqrt_steps: assert property (@(posedge clk) disable iff (rst)
    state == U_SQRT |-> !step[5])
    else $error("square root ran past its last step");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> state == U_IDLE)
    else $error("done held for more than one cycle");

endmodule

// File: hdl/calibrated_block_rms_meter.sv
// ----------------------------------------------------------------------------
// calibrated_block_rms_meter
// Calibrates raw converter samples to current, accumulates squares and emits
// the RMS of each block of block_length samples.
//
//   channel | direction | payload
//   s_      | in        | tdata: raw_sample
//   m_      | out       | tdata: current_value, rms_value, block_index;
//           |           | tuser: rms_valid
//   cfg_    | in        | write: 0 gain, 1 offset, 2 block_length
//
// An item that does not close a block passes from accept through MUL1, CAL,
// SQR, ACC and CHK to DONE, where its result is loaded. An item that closes a
// block waits in ROOT while the root unit divides, takes the square root and
// hands back. One shared multiplier serves calibration and squaring. Reset
// clears the sequencer, accumulator, counts and registers to their defaults.
// A result waiting on m_tready stalls the sequencer only when the next result
// is ready to load.
// ----------------------------------------------------------------------------
module calibrated_block_rms_meter
  import cbrms_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // raw_sample
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,  // current_value, rms_value, block_index
  output logic                       m_tuser,  // rms_valid
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_CAL  = 8'b0000_0100,
    S_SQR  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_ROOT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                   state;
  logic [SAMPLE_BITS-1:0]   sample;
  logic signed [49:0]       mul_q;
  logic signed [23:0]       cur;
  logic [63:0]              square_sum;
  logic [15:0]              sample_count;
  logic [23:0]              last_rms;
  logic [15:0]              blocks_done;
  logic                     done_flag;
  logic signed [23:0]       gain;
  logic signed [23:0]       offset;
  logic [15:0]              block_length;

  logic signed [24:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [42:0]       cal_sum;
  logic [64:0]              acc_sum;
  logic                     out_load;
  root_req_t                req;
  root_rsp_t                rsp;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    if (state == S_SQR) begin
      mul_a = {cur[23], cur};
      mul_b = {cur[23], cur};
    end else begin
      mul_a = $signed({{(25-SAMPLE_BITS){1'b0}}, sample});
      mul_b = {gain[23], gain};
    end
    cal_sum = {mul_q[49], mul_q[49:8]} + {{19{offset[23]}}, offset};
    acc_sum = {1'b0, square_sum} + {18'd0, mul_q[46:0]};
    out_load = (state == S_DONE) && (!m_tvalid || m_tready);
    req.start = (state == S_CHK) && (sample_count == block_length);
    req.dividend = square_sum;
    req.divisor = {sample_count == 16'd0, sample_count};
  end

  cbrms_root_unit u_root (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
      offset <= OFFSET_RESET;
      block_length <= BLOCK_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN: gain <= cfg_data;
        CFG_OFFSET: offset <= cfg_data;
        CFG_BLOCK_LENGTH: block_length <= cfg_data[15:0];
        default: gain <= gain;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      square_sum <= '0;
      sample_count <= '0;
      last_rms <= '0;
      blocks_done <= '0;
      done_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: state <= S_CAL;
        S_CAL: state <= S_SQR;
        S_SQR: state <= S_ACC;
        S_ACC: begin
          square_sum <= acc_sum[64] ? '1 : acc_sum[63:0];
          sample_count <= sample_count + 16'd1;
          state <= S_CHK;
        end
        S_CHK: begin
          if (req.start) begin
            square_sum <= '0;
            sample_count <= '0;
            blocks_done <= blocks_done + 16'd1;
            done_flag <= 1'b1;
            state <= S_ROOT;
          end else begin
            done_flag <= 1'b0;
            state <= S_DONE;
          end
        end
        S_ROOT: begin
          if (rsp.done) begin
            last_rms <= (|rsp.root[31:24]) ? '1 : rsp.root[23:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (state == S_MUL1 || state == S_SQR) begin
      mul_q <= mul_a * mul_b;
    end
    if (state == S_CAL) begin
      if (cal_sum > CUR_MAX) begin
        cur <= CUR_MAX[23:0];
      end else if (cal_sum < CUR_MIN) begin
        cur <= CUR_MIN[23:0];
      end else begin
        cur <= cal_sum[23:0];
      end
    end
    if (out_load) begin
      m_tdata <= {blocks_done, last_rms, cur};
      m_tuser <= done_flag;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in work");

  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_ROOT)
    else $error("root result arrived outside its wait state");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output overwritten before it was taken");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    req.start |-> rsp.idle)
    else $error("root unit started while busy");

endmodule

// File: test/tb_calibrated_block_rms_meter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calibrated_block_rms_meter
// Streams raw samples into the RMS meter and checks every result against a
// behavioural model of calibration, saturating accumulation and block RMS.
// Covers default registers, calibration extremes, an unused register index,
// random blocks under several idling mixes, and block lengths set below the
// running count.
// ----------------------------------------------------------------------------
module tb_calibrated_block_rms_meter;
  import cbrms_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_LANE_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [23:0] current;
    logic        rms_valid;
    logic [23:0] rms;
    logic [15:0] index;
  } meter_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SAMPLE_LANE_W-1:0] s_tdata = '0;  // raw_sample
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;  // current_value, rms_value, block_index
  logic m_tuser;  // rms_valid
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model registers and state
  logic signed [23:0] cal_gain = GAIN_RESET;
  logic signed [23:0] cal_offset = OFFSET_RESET;
  logic [15:0] cal_length = BLOCK_LENGTH_RESET;
  logic [15:0] fill_count = '0;
  logic [63:0] square_sum = '0;
  logic [23:0] held_rms = '0;
  logic [15:0] block_count = '0;

  meter_result_t pending_results[$];
  meter_result_t head;
  int errors = 0;
  int stall_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  calibrated_block_rms_meter #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= v) root = trial;
    end
    return root;
  endfunction

  function automatic meter_result_t predict_meter(input logic [SAMPLE_BITS-1:0] sample);
    meter_result_t r;
    logic signed [63:0] product;
    logic signed [63:0] level;
    logic [63:0] mag;
    logic [63:0] square;
    logic [64:0] total;
    logic [63:0] divisor;
    logic [31:0] root;
    product = $signed({{(64-SAMPLE_BITS){1'b0}}, sample}) * cal_gain;
    level = (product >>> 8) + cal_offset;
    if (level > CUR_MAX) level = CUR_MAX;
    else if (level < CUR_MIN) level = CUR_MIN;
    mag = (level < 0) ? -level : level;
    square = mag * mag;
    total = {1'b0, square_sum} + {1'b0, square};
    square_sum = total[64] ? '1 : total[63:0];
    fill_count = fill_count + 16'd1;
    r.rms_valid = 1'b0;
    if (fill_count == cal_length) begin
      divisor = (fill_count == 16'd0) ? 64'd65536 : {48'd0, fill_count};
      root = int_sqrt(square_sum / divisor);
      held_rms = (root > 32'hFFFFFF) ? 24'hFFFFFF : root[23:0];
      block_count = block_count + 16'd1;
      square_sum = '0;
      fill_count = '0;
      r.rms_valid = 1'b1;
    end
    r.current = level[23:0];
    r.rms = held_rms;
    r.index = block_count;
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1));
    endcase
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'($urandom());
      default: return 24'(GAIN_RESET) + 24'($urandom_range(2000)) - 24'd1000;
    endcase
  endfunction

  function automatic logic [23:0] pick_offset();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom());
      default: return 24'($urandom_range(4095)) - 24'd2048;
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= SAMPLE_LANE_W'(sample);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_meter(sample));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GAIN: cal_gain = value;
      CFG_OFFSET: cal_offset = value;
      CFG_BLOCK_LENGTH: cal_length = value[15:0];
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_sample('0);
    send_sample('1);
    send_sample(SAMPLE_BITS'(1 << (SAMPLE_BITS - 1)));
    wait_results_drained();
    set_reg(CFG_BLOCK_LENGTH, 24'd4);
    send_sample(SAMPLE_BITS'(1));
  endtask

  task automatic test_calibration_extremes();
    wait_results_drained();
    set_reg(CFG_BLOCK_LENGTH, 24'd1);
    set_reg(CFG_GAIN, 24'h7FFFFF);
    set_reg(CFG_OFFSET, 24'h7FFFFF);
    send_sample('1);
    send_sample('0);
    wait_results_drained();
    set_reg(CFG_GAIN, 24'h800000);
    set_reg(CFG_OFFSET, 24'h800000);
    send_sample('1);
    send_sample('0);
    wait_results_drained();
    // negative products round toward minus infinity
    set_reg(CFG_GAIN, 24'hFFFFFF);
    set_reg(CFG_OFFSET, 24'd0);
    send_sample(SAMPLE_BITS'(1));
    send_sample(SAMPLE_BITS'(255));
    send_sample(SAMPLE_BITS'(256));
    wait_results_drained();
    set_reg(CFG_GAIN, 24'd1);
    send_sample(SAMPLE_BITS'(255));
  endtask

  task automatic test_unused_register_index();
    wait_results_drained();
    set_reg(CFG_SPARE, 24'h5A5A5A);
    send_sample('1);
    send_sample(SAMPLE_BITS'(3));
  endtask

  task automatic test_random_blocks(input int tx_pct, input int rx_pct, input int items);
    int sent;
    int burst;
    logic [15:0] span;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < items) begin
      wait_results_drained();
      if ($urandom_range(2) != 0) set_reg(CFG_GAIN, pick_gain());
      if ($urandom_range(2) != 0) set_reg(CFG_OFFSET, pick_offset());
      span = ($urandom_range(9) == 0) ? 16'($urandom_range(17, 300))
                                      : 16'($urandom_range(1, 16));
      // keep the new length above the running count so the block can close
      set_reg(CFG_BLOCK_LENGTH, {8'd0, fill_count + span});
      burst = int'(span) + int'(cal_length) * $urandom_range(0, 2);
      if ($urandom_range(3) == 0) burst = $urandom_range(1, burst);
      if (burst > items - sent) burst = items - sent;
      repeat (burst) send_sample(pick_sample());
      sent += burst;
    end
  endtask

  task automatic test_length_below_count();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_results_drained();
    set_reg(CFG_GAIN, 24'(GAIN_RESET));
    set_reg(CFG_OFFSET, 24'(OFFSET_RESET));
    set_reg(CFG_BLOCK_LENGTH, {8'd0, fill_count + 16'd1});
    send_sample(pick_sample());
    wait_results_drained();
    set_reg(CFG_BLOCK_LENGTH, 24'hFFFF);
    repeat (5) send_sample(pick_sample());
    wait_results_drained();
    // length now below the count: no block closes while the count rises
    set_reg(CFG_BLOCK_LENGTH, 24'd3);
    repeat (20) send_sample(pick_sample());
    wait_results_drained();
    // length zero: the block closes only once the count wraps
    set_reg(CFG_BLOCK_LENGTH, 24'd0);
    repeat (20) send_sample(pick_sample());
  endtask

  task automatic report_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual 'h%0h",
                 $time, m_tdata);
      end else begin
        head = pending_results.pop_front();
        if (m_tdata[23:0] !== head.current)
          report_field("current_value", head.current, m_tdata[23:0]);
        if (m_tuser !== head.rms_valid)
          report_field("rms_valid", 24'(head.rms_valid), 24'(m_tuser));
        if (m_tdata[47:24] !== head.rms)
          report_field("rms_value", head.rms, m_tdata[47:24]);
        if (m_tdata[63:48] !== head.index)
          report_field("block_index", 24'(head.index), 24'(m_tdata[63:48]));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    tx_idle_pct = 31;
    rx_idle_pct = 79;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_calibration_extremes();
    test_unused_register_index();
    test_random_blocks(31, 79, 530);
    test_random_blocks(79, 31, 530);
    test_random_blocks(0, 0, 530);
    test_length_below_count();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
